FILE: hdl/bsl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button short/long press detector.
// No dependencies; every other file of the block imports this package.
package bsl_pkg;

	localparam int BUTTON_COUNT = 3;
	localparam int BUTTON_IDX_W = 2;
	localparam int HOLD_W       = 16;
	localparam int SETTLE_W     = 10;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 1;

	localparam logic [HOLD_W-1:0]   LONG_TICKS_RESET   = 16'd600;
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RESET = 10'd50;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} event_kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 1'd1;

	typedef struct packed {
		logic [HOLD_W-1:0]   long_ticks;
		logic [SETTLE_W-1:0] settle_ticks;
	} bsl_cfg_t;

	typedef struct packed {
		event_kind_t             kind;
		logic [BUTTON_IDX_W-1:0] button;
	} bsl_result_t;

endpackage

FILE: hdl/bsl_lane.sv
`timescale 1ns / 1ps
// One button lane: debounce window, press tracking and hold counting.
// Depends on bsl_pkg.
module bsl_lane
	import bsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cur,
	input  logic        commit,
	input  bsl_cfg_t    cfg,
	output event_kind_t ev
);

	logic                last_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                pressed_q;
	logic                long_q;
	logic [HOLD_W-1:0]   hold_q;

	logic                last_n;
	logic [SETTLE_W-1:0] settle_n;
	logic                pressed_n;
	logic                long_n;
	logic [HOLD_W-1:0]   hold_n;
	logic                check;
	logic                match;

	always_comb begin
		ev     = EV_NONE;
		check  = 1'b0;
		last_n = last_q;
		settle_n = settle_q;
		pressed_n = pressed_q;
		long_n = long_q;
		hold_n = hold_q;

		if (pressed_q && (hold_q != {HOLD_W{1'b1}})) begin
			hold_n = hold_q + 1'b1;
		end

		if (settle_q == '0) begin
			if (cur != last_q) begin
				last_n   = cur;
				settle_n = cfg.settle_ticks;
				check    = (cfg.settle_ticks == '0);
			end
		end else begin
			settle_n = settle_q - 1'b1;
			check    = (settle_q == SETTLE_W'(1));
		end

		match = check && (cur == last_n);

		if (match && !cur && !pressed_n) begin
			pressed_n = 1'b1;
			long_n    = 1'b0;
			hold_n    = '0;
		end

		if (pressed_n && !long_n && (hold_n >= cfg.long_ticks)) begin
			long_n = 1'b1;
			ev     = EV_LONG;
		end

		if (match && cur && pressed_n) begin
			pressed_n = 1'b0;
			if (!long_n && (hold_n < cfg.long_ticks)) begin
				ev = EV_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b1;
			settle_q  <= '0;
			pressed_q <= 1'b0;
			long_q    <= 1'b0;
			hold_q    <= '0;
		end else if (commit) begin
			last_q    <= last_n;
			settle_q  <= settle_n;
			pressed_q <= pressed_n;
			long_q    <= long_n;
			hold_q    <= hold_n;
		end
	end

endmodule

FILE: hdl/bsl_merge.sv
`timescale 1ns / 1ps
// Priority merge of the lane events: lowest reporting button wins.
// Depends on bsl_pkg.
module bsl_merge
	import bsl_pkg::*;
(
	input  event_kind_t       ev [BUTTON_COUNT],
	output logic [BUTTON_COUNT-1:0] keep,
	output bsl_result_t       result
);

	logic found;

	// Lanes up to and including the first reporting one keep their update;
	// lanes above it are held unchanged this tick.
	always_comb begin
		found  = 1'b0;
		keep   = '0;
		result = '{kind: EV_NONE, button: '0};
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			keep[i] = !found;
			if (!found && (ev[i] != EV_NONE)) begin
				found         = 1'b1;
				result.kind   = ev[i];
				result.button = BUTTON_IDX_W'(i);
			end
		end
	end

endmodule

FILE: hdl/bsl_outbuf.sv
`timescale 1ns / 1ps
// Two-entry result buffer that separates the input side from the output stall.
// Depends on bsl_pkg.
module bsl_outbuf
	import bsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bsl_result_t push_data,
	output logic        full,
	output logic        valid,
	input  logic        stall,
	output bsl_result_t data
);

	logic        main_valid_q;
	logic        skid_valid_q;
	bsl_result_t main_q;
	bsl_result_t skid_q;
	logic        take;

	assign take  = main_valid_q && !stall;
	assign full  = skid_valid_q;
	assign valid = main_valid_q;
	assign data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

FILE: hdl/button_short_long_press_detector.sv
`timescale 1ns / 1ps
// Debounce and short/long press detection for three active-low buttons, one
// input transfer per tick. The block accepts one tick per clock cycle while the input
// is not stalled, and its result is registered in the output buffer; the limit is the
// combinational per-tick state update through all button lanes and the priority merge
// because the next tick depends on it. Each tick gives exactly one result: no
// event, a short press or a long press, with the lowest reporting button winning.
// Results wait in a two-entry buffer, so input stall rises only when two results
// are waiting. Configuration is always ready and should only be written while idle.
// Depends on bsl_pkg, bsl_lane, bsl_merge and bsl_outbuf.
module button_short_long_press_detector
	import bsl_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Tick input channel.
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [BUTTON_COUNT-1:0] levels,
	// Result channel.
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [1:0]              event_kind,
	output logic [BUTTON_IDX_W-1:0] button_index,
	// Configuration write channel.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	bsl_cfg_t                cfg_q;
	logic                    accept;
	logic                    buf_full;
	event_kind_t             lane_ev [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] keep;
	bsl_result_t             merged;
	bsl_result_t             out_data;

	// Configuration registers are written directly; the port never holds off.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks   <= LONG_TICKS_RESET;
			cfg_q.settle_ticks <= SETTLE_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LONG_PRESS: cfg_q.long_ticks   <= cfg_data;
				CFG_SETTLE:     cfg_q.settle_ticks <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// A tick transfer happens whenever a tick is offered and the result buffer has room.
	assign item_stall = buf_full;
	assign accept     = item_valid && !item_stall;

	// One lane per button. A lane commits its update only when the tick is
	// accepted and no lower button reported an event on the same tick.
	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
		bsl_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cur    (levels[g]),
			.commit (accept && keep[g]),
			.cfg    (cfg_q),
			.ev     (lane_ev[g])
		);
	end

	bsl_merge u_merge (
		.ev     (lane_ev),
		.keep   (keep),
		.result (merged)
	);

	bsl_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (merged),
		.full      (buf_full),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (out_data)
	);

	assign event_kind   = out_data.kind;
	assign button_index = out_data.button;

endmodule

FILE: hdl/bsl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the button press detector, attached by bind.
// Depends on bsl_pkg and the top level button_short_long_press_detector.
module bsl_checker
	import bsl_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_stall,
	input logic                    result_valid,
	input logic                    result_stall,
	input logic [1:0]              event_kind,
	input logic [BUTTON_IDX_W-1:0] button_index
);

	// An event names a real button and a valid event code.
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (event_kind != 2'd3) && (button_index < BUTTON_IDX_W'(BUTTON_COUNT)))
		else $error("event code or button index out of range");

	// With no event the button index reads zero.
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (event_kind == EV_NONE)) |-> (button_index == '0))
		else $error("button index nonzero without event");

	// Input stall only arises while results are waiting.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no result pending");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(event_kind) && $stable(button_index)))
		else $error("stalled result changed");

endmodule

bind button_short_long_press_detector bsl_checker u_bsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.event_kind   (event_kind),
	.button_index (button_index)
);
